// ===== rtl/mcvp_pkg.sv =====
// shared types and constants for the midi channel voice parser
// no dependencies; imported by mcvp_parser and midi_channel_voice_parser
`default_nettype none

package mcvp_pkg;

   localparam int RxByteWidth  = 8;
   localparam int DataWidth    = 7;
   localparam int KindWidth    = 2;
   localparam int ChannelWidth = 5;

   localparam logic [ChannelWidth-1:0] ChannelReset = 5'd1;

   // event kinds as reported on the result port
   localparam logic [KindWidth-1:0] KIND_NOTE_OFF = 2'd0;
   localparam logic [KindWidth-1:0] KIND_NOTE_ON  = 2'd1;
   localparam logic [KindWidth-1:0] KIND_CONTROL  = 2'd2;

   // high nibble of the voice status bytes that are parsed
   localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
   localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
   localparam logic [3:0] STATUS_CONTROL  = 4'hB;
   // high nibble shared by system common and real-time bytes
   localparam logic [3:0] STATUS_SYSTEM   = 4'hF;

   typedef struct packed {
      logic                 valid;
      logic [KindWidth-1:0] kind;
      logic [DataWidth-1:0] number;
      logic [DataWidth-1:0] value;
   } event_type;

endpackage

`default_nettype wire

// ===== rtl/mcvp_parser.sv =====
// running status state and per-byte decode of note off, note on and control change
// depends on mcvp_pkg
`default_nettype none

module mcvp_parser (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 step_en,
   input  wire logic [mcvp_pkg::RxByteWidth-1:0]     rx_byte,
   input  wire logic [mcvp_pkg::ChannelWidth-1:0]    midi_channel,
   output mcvp_pkg::event_type                       evt
);
   import mcvp_pkg::*;

   logic [RxByteWidth-1:0] running_status_ff, running_status_in;
   logic [DataWidth-1:0]   first_data_ff, first_data_in;
   logic                   have_first_ff, have_first_in;

   logic                   is_voice;
   logic                   is_common;
   logic                   is_data;
   logic                   chan_match;
   logic                   kind_ok;
   logic [KindWidth-1:0]   kind;

   always_comb begin
      is_voice  = rx_byte[7] && (rx_byte[7:4] != STATUS_SYSTEM);
      is_common = (rx_byte[7:4] == STATUS_SYSTEM) && !rx_byte[3];
      is_data   = !rx_byte[7];

      // status low nibble plus one against the one based channel
      chan_match = running_status_ff[7] &&
                   (({1'b0, running_status_ff[3:0]} + ChannelWidth'(1)) == midi_channel);

      kind_ok = 1'b1;
      kind    = KIND_NOTE_OFF;
      unique case (running_status_ff[7:4])
         STATUS_NOTE_OFF: kind = KIND_NOTE_OFF;
         STATUS_NOTE_ON:  kind = KIND_NOTE_ON;
         STATUS_CONTROL:  kind = KIND_CONTROL;
         default:         kind_ok = 1'b0;
      endcase

      running_status_in = running_status_ff;
      first_data_in     = first_data_ff;
      have_first_in     = have_first_ff;
      evt               = '0;

      priority if (is_voice) begin
         running_status_in = rx_byte;
         first_data_in     = '0;
         have_first_in     = 1'b0;
      end else if (is_common) begin
         running_status_in = '0;
      end else if (is_data && chan_match && kind_ok) begin
         if (!have_first_ff) begin
            first_data_in = rx_byte[DataWidth-1:0];
            have_first_in = 1'b1;
         end else begin
            evt.valid     = 1'b1;
            evt.number    = first_data_ff;
            evt.value     = rx_byte[DataWidth-1:0];
            // note on with zero velocity reads as note off
            evt.kind      = ((kind == KIND_NOTE_ON) && (rx_byte[DataWidth-1:0] == '0))
                            ? KIND_NOTE_OFF : kind;
            first_data_in = '0;
            have_first_in = 1'b0;
         end
      end else begin
         // real-time bytes and unmatched data leave the state alone
      end

      if (!step_en) begin
         evt.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_status_ff <= '0;
         first_data_ff     <= '0;
         have_first_ff     <= 1'b0;
      end else if (step_en) begin
         running_status_ff <= running_status_in;
         first_data_ff     <= first_data_in;
         have_first_ff     <= have_first_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/midi_channel_voice_parser.sv =====
// a taken byte is held in the input register, then its event is registered for rsp_
// throughput: one byte per cycle unless a held result waits on rsp_ready
// reset: synchronous active high; clears running status, held data byte, both valid flags,
// and sets the listened channel to 1
// depends on mcvp_pkg and mcvp_parser
`default_nettype none

module midi_channel_voice_parser (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input word: one raw midi byte
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic [mcvp_pkg::RxByteWidth-1:0]     req_rx_byte,
   // result word: one channel voice event
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic [mcvp_pkg::KindWidth-1:0]       rsp_event_kind,
   output      logic [mcvp_pkg::DataWidth-1:0]       rsp_number,
   output      logic [mcvp_pkg::DataWidth-1:0]       rsp_value,
   // configuration: listened channel, one based
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [mcvp_pkg::ChannelWidth-1:0]    csr_midi_channel
);
   import mcvp_pkg::*;

   // channel register, always writable
   logic [ChannelWidth-1:0] midi_channel_ff;

   // input register stage
   logic                    in_valid_ff;
   logic [RxByteWidth-1:0]  in_byte_ff;

   // result register
   logic                    out_valid_ff;
   logic [KindWidth-1:0]    out_kind_ff;
   logic [DataWidth-1:0]    out_number_ff;
   logic [DataWidth-1:0]    out_value_ff;

   logic                    out_free;
   logic                    advance;
   event_type               evt;

   // the held byte moves on whenever the result register is empty or being drained
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   // input register refills in the same cycle it empties
   assign req_ready = !in_valid_ff || out_free;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         midi_channel_ff <= ChannelReset;
      end else if (csr_valid) begin
         midi_channel_ff <= csr_midi_channel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // running status tracking and event decode for the held byte
   mcvp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .rx_byte      (in_byte_ff),
      .midi_channel (midi_channel_ff),
      .evt          (evt)
   );

   // result register: loaded when a byte is decoded, cleared once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= evt.valid;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && evt.valid) begin
         out_kind_ff   <= evt.kind;
         out_number_ff <= evt.number;
         out_value_ff  <= evt.value;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_number     = out_number_ff;
   assign rsp_value      = out_value_ff;

endmodule

`default_nettype wire
